>>> hw/rtl/lpfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 256;
  localparam logic [7:0]  START_BYTE_RESET = 8'h24;
  localparam logic [7:0]  MAX_FRAME_LENGTH = 8'd127;
  localparam logic [7:0]  MIN_FRAME_LENGTH = 8'd2;

  localparam logic [1:0] FUNC_RX      = 2'd0;
  localparam logic [1:0] FUNC_TAKE    = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;
  localparam logic [1:0] FUNC_RELEASE = 2'd3;

  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam logic [2:0] ADDR_START_BYTE = 3'd0;

  // One queued command: memory operation plus the control part of the result.
  typedef struct packed {
    logic [1:0] op;
    logic       buf_sel;
    logic [7:0] pos;
    logic [7:0] wdata;
    logic       frame_done;
    logic       take_valid;
    logic       taken_buffer;
    logic [1:0] ready_flags;
    logic       filling_buffer;
  } cmd_t;

endpackage

>>> hw/rtl/lpfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_front
// Accepts items, runs the framing and ping-pong control, issues commands.
// ----------------------------------------------------------------------------
module lpfr_front #(
  parameter int unsigned BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     start_byte,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     func,
  input  logic [7:0]     rx_byte,
  input  logic           buffer_sel,
  input  logic [7:0]     byte_addr,
  input  logic           q_full,
  output logic           push,
  output lpfr_pkg::cmd_t cmd
);
  import lpfr_pkg::*;

  localparam logic [8:0] BUF_LIMIT = 9'(BUFFER_BYTES);

  logic [7:0] byte_index, byte_index_next;
  logic [7:0] expected_length, expected_length_next;
  logic       fill_select, fill_select_next;
  logic       ready_zero, ready_zero_next;
  logic       ready_one, ready_one_next;
  logic       finish;
  logic [7:0] index_inc;
  logic       bad_length;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign index_inc  = byte_index + 8'd1;
  assign bad_length = (rx_byte < MIN_FRAME_LENGTH) || (rx_byte > MAX_FRAME_LENGTH) ||
                      ({1'b0, rx_byte} > BUF_LIMIT);

  always_comb begin
    byte_index_next      = byte_index;
    expected_length_next = expected_length;
    fill_select_next     = fill_select;
    ready_zero_next      = ready_zero;
    ready_one_next       = ready_one;
    finish               = 1'b0;
    cmd                  = '0;
    cmd.op               = OP_NONE;
    cmd.buf_sel          = fill_select;
    cmd.wdata            = rx_byte;

    unique case (func)
      FUNC_RX: begin
        if (byte_index == 8'd0) begin
          if (rx_byte == start_byte) begin
            cmd.op          = OP_WRITE;
            cmd.pos         = 8'd0;
            byte_index_next = 8'd1;
          end
        end else if (byte_index == 8'd1) begin
          cmd.op  = OP_WRITE;
          cmd.pos = 8'd1;
          if (bad_length) begin
            byte_index_next      = 8'd0;
            expected_length_next = 8'd0;
          end else begin
            expected_length_next = rx_byte;
            byte_index_next      = 8'd2;
            finish               = (rx_byte == MIN_FRAME_LENGTH);
          end
        end else begin
          cmd.op          = OP_WRITE;
          cmd.pos         = byte_index;
          byte_index_next = index_inc;
          finish          = (expected_length != 8'd0) && (index_inc == expected_length);
        end
      end
      FUNC_TAKE: begin
        if (ready_zero) begin
          cmd.take_valid   = 1'b1;
          cmd.taken_buffer = 1'b0;
          ready_zero_next  = 1'b0;
        end else if (ready_one) begin
          cmd.take_valid   = 1'b1;
          cmd.taken_buffer = 1'b1;
          ready_one_next   = 1'b0;
        end
      end
      FUNC_READ: begin
        if ({1'b0, byte_addr} < BUF_LIMIT) begin
          cmd.op      = OP_READ;
          cmd.buf_sel = buffer_sel;
          cmd.pos     = byte_addr;
        end
      end
      FUNC_RELEASE: begin
        cmd.op      = OP_RELEASE;
        cmd.buf_sel = buffer_sel;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase

    if (finish) begin
      cmd.frame_done       = 1'b1;
      byte_index_next      = 8'd0;
      expected_length_next = 8'd0;
      if (fill_select) begin
        if (!ready_one) begin
          fill_select_next = 1'b0; ready_one_next = 1'b1; ready_zero_next = 1'b0;
        end else begin
          fill_select_next = 1'b1; ready_zero_next = 1'b1; ready_one_next = 1'b0;
        end
      end else begin
        if (!ready_zero) begin
          fill_select_next = 1'b1; ready_zero_next = 1'b1; ready_one_next = 1'b0;
        end else begin
          fill_select_next = 1'b0; ready_one_next = 1'b1; ready_zero_next = 1'b0;
        end
      end
    end

    cmd.ready_flags    = {ready_one_next, ready_zero_next};
    cmd.filling_buffer = fill_select_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= 8'd0;
      expected_length <= 8'd0;
      fill_select     <= 1'b0;
      ready_zero      <= 1'b0;
      ready_one       <= 1'b0;
    end else if (push) begin
      byte_index      <= byte_index_next;
      expected_length <= expected_length_next;
      fill_select     <= fill_select_next;
      ready_zero      <= ready_zero_next;
      ready_one       <= ready_one_next;
    end
  end

endmodule

>>> hw/rtl/lpfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_queue
// Two-entry command queue between the control front and the buffer back.
// ----------------------------------------------------------------------------
module lpfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpfr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output lpfr_pkg::cmd_t head
);
  import lpfr_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/lpfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfr_back
// Executes buffer writes, reads and releases; holds the result register.
// ----------------------------------------------------------------------------
module lpfr_back #(
  parameter int unsigned BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lpfr_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           frame_done,
  output logic           take_valid,
  output logic           taken_buffer,
  output logic [7:0]     read_data,
  output logic [1:0]     ready_flags,
  output logic           filling_buffer
);
  import lpfr_pkg::*;

  localparam int unsigned POS_W = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W = POS_W + 1;

  // Live bytes of a buffer since its last release: a prefix written by
  // frames that started after the release, plus one run left by a frame
  // that was in progress when the release came.
  logic [7:0]       frame_store [2][BUFFER_BYTES];
  logic [CNT_W-1:0] fill_len [2];
  logic [CNT_W-1:0] island_lo [2];
  logic [CNT_W-1:0] island_hi [2];
  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] pos_inc;
  logic             sel;
  logic             pos_live;
  logic [7:0]       rd_data;
  logic             rd_hit;
  cmd_t             res;

  assign pop     = q_valid && (!out_valid || !out_stall);
  assign pos     = head.pos[POS_W-1:0];
  assign sel     = head.buf_sel;
  assign pos_ext = {1'b0, pos};
  assign pos_inc = pos_ext + CNT_W'(1);
  assign pos_live = (pos_ext < fill_len[sel]) ||
                    ((pos_ext >= island_lo[sel]) && (pos_ext < island_hi[sel]));

  always_ff @(posedge clk) begin
    if (pop && head.op == OP_WRITE) begin
      frame_store[head.buf_sel][pos] <= head.wdata;
    end
    if (pop) begin
      rd_data <= frame_store[head.buf_sel][pos];
      res     <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_len[0]  <= '0;
      fill_len[1]  <= '0;
      island_lo[0] <= '0;
      island_lo[1] <= '0;
      island_hi[0] <= '0;
      island_hi[1] <= '0;
      rd_hit       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        rd_hit    <= (head.op == OP_READ) && pos_live;
        if (head.op == OP_WRITE) begin
          if (pos_ext == fill_len[sel]) begin
            fill_len[sel] <= pos_inc;
          end else if (pos_ext > fill_len[sel]) begin
            if (island_lo[sel] == island_hi[sel]) begin
              island_lo[sel] <= pos_ext;
              island_hi[sel] <= pos_inc;
            end else if (pos_ext == island_hi[sel]) begin
              island_hi[sel] <= pos_inc;
            end
          end
        end else if (head.op == OP_RELEASE) begin
          fill_len[sel]  <= '0;
          island_lo[sel] <= '0;
          island_hi[sel] <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign frame_done     = res.frame_done;
  assign take_valid     = res.take_valid;
  assign taken_buffer   = res.taken_buffer;
  assign read_data      = rd_hit ? rd_data : 8'd0;
  assign ready_flags    = res.ready_flags;
  assign filling_buffer = res.filling_buffer;

endmodule

>>> hw/rtl/length_prefixed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Path: an accepted item is written into the command queue, then popped into
//   the output result register when the output side does not stall.
// Throughput: one item per cycle while in_stall is low; the two-entry command
//   queue and the single buffer memory port each handle one item a cycle.
// Reset: clears framing state, ready flags, buffer fill tracking and the
//   queue; the start byte returns to '$'. No clearing pass, items accepted
//   at once.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic        buffer_sel,
  input  logic [7:0]  byte_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_done,
  output logic        take_valid,
  output logic        taken_buffer,
  output logic [7:0]  read_data,
  output logic [1:0]  ready_flags,
  output logic        filling_buffer
);
  import lpfr_pkg::*;

  logic [7:0] start_byte;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  cmd_t       push_cmd;
  cmd_t       head;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_START_BYTE) ? {24'd0, start_byte} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_START_BYTE) begin
      start_byte <= pwdata[7:0];
    end
  end

  lpfr_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .rx_byte    (rx_byte),
    .buffer_sel (buffer_sel),
    .byte_addr  (byte_addr),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  lpfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  lpfr_back #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_done     (frame_done),
    .take_valid     (take_valid),
    .taken_buffer   (taken_buffer),
    .read_data      (read_data),
    .ready_flags    (ready_flags),
    .filling_buffer (filling_buffer)
  );

endmodule
